>>> hw/rtl/b32enc_pkg.sv
// b32enc_pkg: shared types, constants and the character table of the base32 encoder
// no dependencies; used by every module under hw/rtl
`timescale 1ns / 1ps
package b32enc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MAX_CHARS   = 8;

   localparam logic [6:0] PAD_CHAR = 7'd61;

   // one accepted byte, worked out into the characters it causes
   typedef struct packed {
      logic [4:0] sym0;
      logic [4:0] sym1;
      logic [4:0] sym2;    // flush symbol on the last byte
      logic [1:0] nsym;    // symbols from the table, 1..3
      logic [2:0] tot_m1;  // symbols plus padding, minus one
      logic       last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] b32_char(input logic [4:0] sym);
      logic [6:0] ch;
      if (sym < 5'd26) begin
         ch = 7'd65 + {2'b00, sym};
      end else begin
         ch = 7'd24 + {2'b00, sym};  // 26 maps to '2' (50)
      end
      return ch;
   endfunction

endpackage

>>> hw/rtl/b32enc_front.sv
// b32enc_front: takes bytes, keeps the leftover bits and group position, builds jobs
// depends on b32enc_pkg
`timescale 1ns / 1ps
module b32enc_front
   import b32enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output job_type    job
);

   logic [3:0]  left_bits_ff, left_bits_in;
   logic [2:0]  left_cnt_ff, left_cnt_in;
   logic [2:0]  group_pos_ff, group_pos_in;
   logic        pad_en_ff;

   logic [11:0] buf_w;
   logic        two;
   logic [2:0]  rem;
   logic [1:0]  nsym;
   logic [2:0]  pos_after;
   logic [2:0]  pads;
   logic [3:0]  total;
   logic [3:0]  avail;

   always_comb begin
      buf_w = {left_bits_ff, data_byte};
      two   = (left_cnt_ff >= 3'd2);
      rem   = two ? (left_cnt_ff - 3'd2) : (left_cnt_ff + 3'd3);

      job.sym0 = 5'(buf_w >> (left_cnt_ff + 3'd3));
      // with only one full symbol the flush symbol takes the second slot
      job.sym1 = two ? 5'(buf_w >> (left_cnt_ff - 3'd2)) : 5'(buf_w << (3'd5 - rem));
      job.sym2 = 5'(buf_w << (3'd5 - rem));

      nsym = 2'd1 + {1'b0, two} + {1'b0, (last_byte && (rem != 3'd0))};
      pos_after = group_pos_ff + {1'b0, nsym};
      pads = (last_byte && pad_en_ff) ? (3'd0 - pos_after) : 3'd0;
      // never more than eight characters for one byte
      avail = 4'(MAX_CHARS) - {2'b00, nsym};
      if ({1'b0, pads} > avail) begin
         pads = avail[2:0];
      end
      total = {2'b00, nsym} + {1'b0, pads};

      job.nsym   = nsym;
      job.tot_m1 = 3'(total - 4'd1);
      job.last   = last_byte;

      left_bits_in = buf_w[3:0] & 4'((5'd1 << rem) - 5'd1);
      left_cnt_in  = rem;
      group_pos_in = pos_after;
      if (last_byte) begin
         left_bits_in = 4'd0;
         left_cnt_in  = 3'd0;
         group_pos_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_bits_ff <= 4'd0;
         left_cnt_ff  <= 3'd0;
         group_pos_ff <= 3'd0;
         pad_en_ff    <= 1'b1;
      end else begin
         if (accept) begin
            left_bits_ff <= left_bits_in;
            left_cnt_ff  <= left_cnt_in;
            group_pos_ff <= group_pos_in;
         end
         if (csr_write_enable) begin
            pad_en_ff <= csr_write_data;
         end
      end
   end

endmodule

>>> hw/rtl/b32enc_queue.sv
// b32enc_queue: short job queue between front and back, first word shown ahead
// depends on b32enc_pkg
`timescale 1ns / 1ps
module b32enc_queue
   import b32enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> hw/rtl/b32enc_back.sv
// b32enc_back: walks each job one character per cycle into the output register while rsp_stall is low
// depends on b32enc_pkg
`timescale 1ns / 1ps
module b32enc_back
   import b32enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_out_last
);

   logic [2:0] idx_ff;
   logic       valid_ff;
   logic [6:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;
   logic [4:0] sym;

   assign load   = head_valid && (!valid_ff || !rsp_stall);
   assign at_end = (idx_ff == head_job.tot_m1);
   assign pop    = load && at_end;

   always_comb begin
      case (idx_ff[1:0])
         2'd0:    sym = head_job.sym0;
         2'd1:    sym = head_job.sym1;
         default: sym = head_job.sym2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= at_end ? 3'd0 : (idx_ff + 3'd1);
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= (idx_ff < {1'b0, head_job.nsym}) ? b32_char(sym) : PAD_CHAR;
         last_ff <= head_job.last && at_end;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

endmodule

>>> hw/rtl/base32_byte_encoder.sv
// channel | direction | handshake          | payload
// req_    | in        | req_valid/req_stall | req_data_byte[7:0], req_last_byte
// rsp_    | out       | rsp_valid/rsp_stall | rsp_out_char[6:0], rsp_out_last
// csr_    | in        | csr_write_enable    | csr_write_data (pad enable)
//
// one character leaves per cycle while rsp_stall is low; a byte gives one or two characters,
// two to eight on the last byte of a message (flush symbol and padding)
// a byte is taken in any cycle the two-entry job queue is not full
// an rsp_stall holds the output register; the front keeps filling the queue
// reset is synchronous; pad enable resets to one, all message state to zero
// depends on b32enc_pkg, b32enc_front, b32enc_queue, b32enc_back
`timescale 1ns / 1ps
module base32_byte_encoder
   import b32enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_out_last
);

   job_type          new_job, head_job;
   queue_status_type qstat;
   logic             accept;
   logic             pop;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   b32enc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .data_byte        (req_data_byte),
      .last_byte        (req_last_byte),
      .job              (new_job)
   );

   b32enc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (new_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (qstat)
   );

   b32enc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .head_valid   (!qstat.empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

   // nothing is shown in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue both full and empty");

   // every character shown is from the alphabet or padding
   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_char >= 7'd65 && rsp_out_char <= 7'd90) ||
                     (rsp_out_char >= 7'd50 && rsp_out_char <= 7'd55) ||
                     (rsp_out_char == PAD_CHAR)))
      else $error("illegal output character");

endmodule
